// ----- hdl/bal_pkg.sv -----
`default_nettype none
package bal_pkg;

   localparam int DEF_MAX_POOL_ORDER  = 16;
   localparam int DEF_MIN_BLOCK_ORDER = 6;
   localparam int DEF_HEADER_BYTES    = 24;

   localparam int SIZE_W   = 17;
   localparam int ADDR_W   = 16;
   localparam int CFG_W    = 5;
   localparam int STATUS_W = 2;
   localparam int TAG_W    = 2;

   localparam logic [STATUS_W-1:0] STATUS_ALLOC_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ALLOC_REFUSED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FREED         = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FREE_IGNORED  = 2'd3;

   localparam logic [TAG_W-1:0] TAG_UNUSED   = 2'd0;
   localparam logic [TAG_W-1:0] TAG_AVAIL    = 2'd1;
   localparam logic [TAG_W-1:0] TAG_RESERVED = 2'd2;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0] user_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   granted_address;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // datapath micro-operations
   typedef enum logic [4:0] {
      OP_NOP, OP_LOAD, OP_CLR, OP_INIT, OP_KSTEP, OP_TSTART, OP_TSTEP, OP_TTAKE,
      OP_UNLINK, OP_SPLIT1, OP_SPLIT2, OP_ADONE, OP_FMARK, OP_FBUD, OP_FMERGE,
      OP_FGROW, OP_PUSH1, OP_PUSH2
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                rsp_fire;
      logic [STATUS_W-1:0] rsp_code;
   } cmd_type;

   typedef struct packed {
      logic mode;
      logic bad_size;
      logic k_over;
      logic k_fit;
      logic t_over;
      logic t_empty;
      logic t_gt_k;
      logic f_bad;
      logic not_res;
      logic can_merge;
      logic bud_ok;
      logic clr_last;
   } stat_type;

endpackage
`default_nettype wire

// ----- hdl/bal_datapath.sv -----
`default_nettype none
module bal_datapath #(
   parameter int MAX_POOL_ORDER  = bal_pkg::DEF_MAX_POOL_ORDER,
   parameter int MIN_BLOCK_ORDER = bal_pkg::DEF_MIN_BLOCK_ORDER,
   parameter int HEADER_BYTES    = bal_pkg::DEF_HEADER_BYTES
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire bal_pkg::cmd_type           cmd,
   input  wire bal_pkg::req_type           req_payload,
   input  wire logic                       csr_write_enable,
   input  wire logic [bal_pkg::CFG_W-1:0]  csr_write_data,
   output bal_pkg::stat_type               stat,
   output logic                            rsp_strobe,
   output bal_pkg::rsp_type                rsp_payload
);

   localparam int SW        = MAX_POOL_ORDER - MIN_BLOCK_ORDER;
   localparam int NUM_SLOTS = 1 << SW;
   localparam int LW        = SW + 1;
   localparam int OW        = $clog2(MAX_POOL_ORDER + 2);
   localparam int HIW       = $clog2(MAX_POOL_ORDER + 1);
   localparam int NW        = bal_pkg::SIZE_W + 1;
   localparam int GW        = (MAX_POOL_ORDER + 1 > bal_pkg::ADDR_W) ?
                              MAX_POOL_ORDER + 1 : bal_pkg::ADDR_W;
   localparam int HW        = bal_pkg::TAG_W + OW;

   localparam logic [LW-1:0] NIL   = LW'(NUM_SLOTS);
   localparam logic [OW-1:0] MIN_K = OW'(MIN_BLOCK_ORDER);
   localparam logic [OW-1:0] MAX_K = OW'(MAX_POOL_ORDER);
   localparam logic [bal_pkg::ADDR_W-1:0] HDR_A = bal_pkg::ADDR_W'(HEADER_BYTES);
   localparam logic [bal_pkg::ADDR_W-1:0] MIN_MASK =
      bal_pkg::ADDR_W'((1 << MIN_BLOCK_ORDER) - 1);

   // header and link memories
   logic [HW-1:0] hdr_mem  [NUM_SLOTS];
   logic [LW-1:0] next_mem [NUM_SLOTS];
   logic [LW-1:0] prev_mem [NUM_SLOTS];
   logic [HW-1:0] hdr_rd_ff;
   logic [LW-1:0] next_rd_ff, prev_rd_ff;

   logic          hdr_we, hdr_re, next_we, prev_we, link_re;
   logic [SW-1:0] hdr_waddr, hdr_raddr, next_waddr, prev_waddr, link_raddr;
   logic [HW-1:0] hdr_wdata;
   logic [LW-1:0] next_wdata, prev_wdata;

   always_ff @(posedge clock) begin
      if (hdr_we) hdr_mem[hdr_waddr] <= hdr_wdata;
      if (hdr_re) hdr_rd_ff <= hdr_mem[hdr_raddr];
   end
   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_waddr] <= next_wdata;
      if (link_re) next_rd_ff <= next_mem[link_raddr];
   end
   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
      if (link_re) prev_rd_ff <= prev_mem[link_raddr];
   end

   // working registers
   logic [OW-1:0]                  pool_ff, k_ff, k_in, t_ff, t_in;
   logic                           mode_ff, mode_in;
   logic [bal_pkg::SIZE_W-1:0]     size_ff, size_in;
   logic [bal_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   logic [SW-1:0]                  s_ff, s_in, clr_ff, clr_in;
   logic [LW-1:0]                  b_ff, b_in, h_ff, h_in;
   logic [LW-1:0]                  head_ff [MAX_POOL_ORDER+1];
   logic                           head_we;
   logic [HIW-1:0]                 head_widx;
   logic [LW-1:0]                  head_wdata;
   logic                           rsp_strobe_ff, rsp_strobe_in;
   bal_pkg::rsp_type               rsp_ff, rsp_in;
   logic [OW-1:0]                  pool_cfg;

   // derived values
   logic [OW-1:0]              tn, list_idx, rd_order;
   logic [bal_pkg::TAG_W-1:0]  rd_tag;
   logic [LW-1:0]              head_t, head_k, head_tn, split_b, bud_b, lnk_n, lnk_p;
   logic [NW-1:0]              need;
   logic [bal_pkg::ADDR_W-1:0] req_start, blk_start;
   logic [SW-1:0]              req_slot;
   logic [GW-1:0]              grant;

   always_comb begin
      int v;
      v = int'(csr_write_data);
      if (v < MIN_BLOCK_ORDER) v = MIN_BLOCK_ORDER;
      if (v > MAX_POOL_ORDER) v = MAX_POOL_ORDER;
      pool_cfg = OW'(v);
   end

   assign tn       = t_ff - OW'(1);
   assign rd_tag   = hdr_rd_ff[HW-1 -: bal_pkg::TAG_W];
   assign rd_order = hdr_rd_ff[OW-1:0];
   assign lnk_n    = next_rd_ff;
   assign lnk_p    = prev_rd_ff;

   always_comb begin
      head_t  = NIL;
      head_k  = NIL;
      head_tn = NIL;
      if (t_ff <= MAX_K) head_t  = head_ff[t_ff[HIW-1:0]];
      if (k_ff <= MAX_K) head_k  = head_ff[k_ff[HIW-1:0]];
      if (tn <= MAX_K)   head_tn = head_ff[tn[HIW-1:0]];
   end

   assign split_b   = LW'(s_ff) + (LW'(1) << (tn - MIN_K));
   assign bud_b     = LW'(s_ff) ^ (LW'(1) << (k_ff - MIN_K));
   assign need      = NW'(size_ff) + NW'(HEADER_BYTES);
   assign req_start = req_payload.user_address - HDR_A;
   assign req_slot  = SW'(req_start >> MIN_BLOCK_ORDER);
   assign blk_start = addr_ff - HDR_A;
   assign grant     = (GW'(s_ff) << MIN_BLOCK_ORDER) + GW'(HEADER_BYTES);

   // status toward the controller
   always_comb begin
      stat.mode     = mode_ff;
      stat.bad_size = (size_ff == '0) ||
                      ((int'(pool_ff) < bal_pkg::SIZE_W) &&
                       (size_ff > (bal_pkg::SIZE_W'(1) << pool_ff)));
      stat.k_over   = k_ff > pool_ff;
      stat.k_fit    = (int'(k_ff) >= NW) || ((NW'(1) << k_ff) >= need);
      stat.t_over   = t_ff > pool_ff;
      stat.t_empty  = head_t[SW];
      stat.t_gt_k   = t_ff > k_ff;
      stat.f_bad    = (addr_ff < HDR_A) ||
                      ((int'(pool_ff) < bal_pkg::ADDR_W) &&
                       ((bal_pkg::ADDR_W+1)'(addr_ff) >=
                        ((bal_pkg::ADDR_W+1)'(1) << pool_ff))) ||
                      ((blk_start & MIN_MASK) != '0) ||
                      ((32'(blk_start) >> MAX_POOL_ORDER) != 32'd0);
      stat.not_res  = rd_tag != bal_pkg::TAG_RESERVED;
      stat.can_merge = (k_ff < pool_ff) && (k_ff >= MIN_K) && !bud_b[SW];
      stat.bud_ok   = (rd_tag == bal_pkg::TAG_AVAIL) && (rd_order == k_ff);
      stat.clr_last = clr_ff == SW'(NUM_SLOTS - 1);
   end

   assign list_idx = (cmd.op == bal_pkg::OP_UNLINK) ? t_ff : k_ff;

   always_comb begin
      mode_in = mode_ff;  size_in = size_ff;  addr_in = addr_ff;
      k_in = k_ff;  t_in = t_ff;  s_in = s_ff;  b_in = b_ff;  h_in = h_ff;
      clr_in = clr_ff;
      hdr_we = 1'b0;  hdr_waddr = '0;  hdr_wdata = '0;
      hdr_re = 1'b0;  hdr_raddr = '0;
      next_we = 1'b0; next_waddr = '0; next_wdata = '0;
      prev_we = 1'b0; prev_waddr = '0; prev_wdata = '0;
      link_re = 1'b0; link_raddr = '0;
      head_we = 1'b0; head_widx = '0;  head_wdata = '0;
      case (cmd.op)
         bal_pkg::OP_LOAD: begin
            mode_in   = req_payload.mode;
            size_in   = req_payload.request_size;
            addr_in   = req_payload.user_address;
            k_in      = MIN_K;
            s_in      = req_slot;
            hdr_re    = 1'b1;
            hdr_raddr = req_slot;
         end
         bal_pkg::OP_CLR: begin
            hdr_we    = 1'b1;
            hdr_waddr = clr_ff;
            hdr_wdata = {bal_pkg::TAG_UNUSED, OW'(0)};
            clr_in    = clr_ff + SW'(1);
         end
         bal_pkg::OP_INIT: begin
            hdr_we  = 1'b1;  hdr_wdata  = {bal_pkg::TAG_AVAIL, pool_ff};
            next_we = 1'b1;  next_wdata = NIL;
            prev_we = 1'b1;  prev_wdata = NIL;
         end
         bal_pkg::OP_KSTEP:  k_in = k_ff + OW'(1);
         bal_pkg::OP_TSTART: t_in = k_ff;
         bal_pkg::OP_TSTEP:  t_in = t_ff + OW'(1);
         bal_pkg::OP_TTAKE: begin
            s_in       = head_t[SW-1:0];
            link_re    = 1'b1;
            link_raddr = head_t[SW-1:0];
         end
         bal_pkg::OP_UNLINK, bal_pkg::OP_FMERGE: begin
            if (lnk_p[SW]) begin
               head_we    = 1'b1;
               head_widx  = list_idx[HIW-1:0];
               head_wdata = lnk_n;
            end else begin
               next_we    = 1'b1;
               next_waddr = lnk_p[SW-1:0];
               next_wdata = lnk_n;
            end
            if (!lnk_n[SW]) begin
               prev_we    = 1'b1;
               prev_waddr = lnk_n[SW-1:0];
               prev_wdata = lnk_p;
            end
            if (cmd.op == bal_pkg::OP_FMERGE) begin
               // upper buddy header is absorbed
               hdr_we    = 1'b1;
               hdr_wdata = {bal_pkg::TAG_UNUSED, OW'(0)};
               if (b_ff[SW-1:0] < s_ff) begin
                  hdr_waddr = s_ff;
                  s_in      = b_ff[SW-1:0];
               end else begin
                  hdr_waddr = b_ff[SW-1:0];
               end
            end
         end
         bal_pkg::OP_SPLIT1: begin
            t_in = tn;
            b_in = split_b;
            h_in = head_tn;
            if (!split_b[SW]) begin
               hdr_we     = 1'b1;
               hdr_waddr  = split_b[SW-1:0];
               hdr_wdata  = {bal_pkg::TAG_AVAIL, tn};
               next_we    = 1'b1;
               next_waddr = split_b[SW-1:0];
               next_wdata = head_tn;
               prev_we    = 1'b1;
               prev_waddr = split_b[SW-1:0];
               prev_wdata = NIL;
            end
         end
         bal_pkg::OP_SPLIT2: begin
            if (!b_ff[SW]) begin
               if (!h_ff[SW]) begin
                  prev_we    = 1'b1;
                  prev_waddr = h_ff[SW-1:0];
                  prev_wdata = b_ff;
               end
               head_we    = 1'b1;
               head_widx  = t_ff[HIW-1:0];
               head_wdata = b_ff;
            end
         end
         bal_pkg::OP_ADONE: begin
            hdr_we    = 1'b1;
            hdr_waddr = s_ff;
            hdr_wdata = {bal_pkg::TAG_RESERVED, k_ff};
         end
         bal_pkg::OP_FMARK: begin
            hdr_we    = 1'b1;
            hdr_waddr = s_ff;
            hdr_wdata = {bal_pkg::TAG_AVAIL, rd_order};
            k_in      = (rd_order > pool_ff) ? pool_ff : rd_order;
         end
         bal_pkg::OP_FBUD: begin
            b_in       = bud_b;
            hdr_re     = 1'b1;
            hdr_raddr  = bud_b[SW-1:0];
            link_re    = 1'b1;
            link_raddr = bud_b[SW-1:0];
         end
         bal_pkg::OP_FGROW: begin
            hdr_we    = 1'b1;
            hdr_waddr = s_ff;
            hdr_wdata = {bal_pkg::TAG_AVAIL, k_ff + OW'(1)};
            k_in      = k_ff + OW'(1);
         end
         bal_pkg::OP_PUSH1: begin
            h_in       = head_k;
            next_we    = 1'b1;
            next_waddr = s_ff;
            next_wdata = head_k;
            prev_we    = 1'b1;
            prev_waddr = s_ff;
            prev_wdata = NIL;
         end
         bal_pkg::OP_PUSH2: begin
            if (!h_ff[SW]) begin
               prev_we    = 1'b1;
               prev_waddr = h_ff[SW-1:0];
               prev_wdata = LW'(s_ff);
            end
            head_we    = 1'b1;
            head_widx  = k_ff[HIW-1:0];
            head_wdata = LW'(s_ff);
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_strobe_in = cmd.rsp_fire;
      rsp_in        = rsp_ff;
      if (cmd.rsp_fire) begin
         rsp_in.status          = cmd.rsp_code;
         rsp_in.granted_address = (cmd.rsp_code == bal_pkg::STATUS_ALLOC_OK) ?
                                  grant[bal_pkg::ADDR_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;  size_ff <= size_in;  addr_ff <= addr_in;
      k_ff <= k_in;  t_ff <= t_in;  s_ff <= s_in;  b_ff <= b_in;  h_ff <= h_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff       <= MAX_K;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i <= MAX_POOL_ORDER; i++)
            head_ff[i] <= (i == MAX_POOL_ORDER) ? '0 : NIL;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_enable) begin
            pool_ff <= pool_cfg;
            clr_ff  <= '0;
            for (int i = 0; i <= MAX_POOL_ORDER; i++)
               head_ff[i] <= (i == int'(pool_cfg)) ? '0 : NIL;
         end else begin
            clr_ff <= clr_in;
            if (head_we) head_ff[head_widx] <= head_wdata;
         end
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   a_refuse_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_payload.status != bal_pkg::STATUS_ALLOC_OK)
      |-> (rsp_payload.granted_address == '0))
      else $error("non-grant beat carries an address");

endmodule
`default_nettype wire

// ----- hdl/bal_ctrl.sv -----
`default_nettype none
module bal_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              csr_write_enable,
   input  wire bal_pkg::stat_type stat,
   output bal_pkg::cmd_type       cmd,
   output logic                   busy
);

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_CLR    = 13'b0000000000010,
      S_INIT   = 13'b0000000000100,
      S_DISP   = 13'b0000000001000,
      S_KSCAN  = 13'b0000000010000,
      S_TSCAN  = 13'b0000000100000,
      S_UNLINK = 13'b0000001000000,
      S_SPLIT  = 13'b0000010000000,
      S_SPLIT2 = 13'b0000100000000,
      S_FCHK   = 13'b0001000000000,
      S_FBUD   = 13'b0010000000000,
      S_FGROW  = 13'b0100000000000,
      S_PUSH2  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = bal_pkg::OP_NOP;
      cmd.rsp_fire = 1'b0;
      cmd.rsp_code = bal_pkg::STATUS_ALLOC_OK;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = bal_pkg::OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_CLR: begin
            cmd.op = bal_pkg::OP_CLR;
            if (stat.clr_last) state_in = S_INIT;
         end
         S_INIT: begin
            cmd.op   = bal_pkg::OP_INIT;
            state_in = S_IDLE;
         end
         S_DISP: begin
            if (stat.mode == bal_pkg::MODE_ALLOC) begin
               if (stat.bad_size) begin
                  cmd.rsp_fire = 1'b1;
                  cmd.rsp_code = bal_pkg::STATUS_ALLOC_REFUSED;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_KSCAN;
               end
            end else if (stat.f_bad || stat.not_res) begin
               cmd.rsp_fire = 1'b1;
               cmd.rsp_code = bal_pkg::STATUS_FREE_IGNORED;
               state_in     = S_IDLE;
            end else begin
               cmd.op   = bal_pkg::OP_FMARK;
               state_in = S_FCHK;
            end
         end
         S_KSCAN: begin
            if (stat.k_over) begin
               cmd.rsp_fire = 1'b1;
               cmd.rsp_code = bal_pkg::STATUS_ALLOC_REFUSED;
               state_in     = S_IDLE;
            end else if (stat.k_fit) begin
               cmd.op   = bal_pkg::OP_TSTART;
               state_in = S_TSCAN;
            end else begin
               cmd.op = bal_pkg::OP_KSTEP;
            end
         end
         S_TSCAN: begin
            if (stat.t_over) begin
               cmd.rsp_fire = 1'b1;
               cmd.rsp_code = bal_pkg::STATUS_ALLOC_REFUSED;
               state_in     = S_IDLE;
            end else if (stat.t_empty) begin
               cmd.op = bal_pkg::OP_TSTEP;
            end else begin
               cmd.op   = bal_pkg::OP_TTAKE;
               state_in = S_UNLINK;
            end
         end
         S_UNLINK: begin
            cmd.op   = bal_pkg::OP_UNLINK;
            state_in = S_SPLIT;
         end
         S_SPLIT: begin
            if (stat.t_gt_k) begin
               cmd.op   = bal_pkg::OP_SPLIT1;
               state_in = S_SPLIT2;
            end else begin
               cmd.op       = bal_pkg::OP_ADONE;
               cmd.rsp_fire = 1'b1;
               cmd.rsp_code = bal_pkg::STATUS_ALLOC_OK;
               state_in     = S_IDLE;
            end
         end
         S_SPLIT2: begin
            cmd.op   = bal_pkg::OP_SPLIT2;
            state_in = S_SPLIT;
         end
         S_FCHK: begin
            if (stat.can_merge) begin
               cmd.op   = bal_pkg::OP_FBUD;
               state_in = S_FBUD;
            end else begin
               cmd.op   = bal_pkg::OP_PUSH1;
               state_in = S_PUSH2;
            end
         end
         S_FBUD: begin
            if (stat.bud_ok) begin
               cmd.op   = bal_pkg::OP_FMERGE;
               state_in = S_FGROW;
            end else begin
               cmd.op   = bal_pkg::OP_PUSH1;
               state_in = S_PUSH2;
            end
         end
         S_FGROW: begin
            cmd.op   = bal_pkg::OP_FGROW;
            state_in = S_FCHK;
         end
         S_PUSH2: begin
            cmd.op       = bal_pkg::OP_PUSH2;
            cmd.rsp_fire = 1'b1;
            cmd.rsp_code = bal_pkg::STATUS_FREED;
            state_in     = S_IDLE;
         end
         default: state_in = S_CLR;
      endcase
      // a pool order write restarts the clear pass
      if (csr_write_enable) begin
         cmd.op       = bal_pkg::OP_NOP;
         cmd.rsp_fire = 1'b0;
         state_in     = S_CLR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLR;
      else       state_ff <= state_in;
   end

   assign busy = state_ff != S_IDLE;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted beat did not raise busy");

   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> (state_ff == S_CLR))
      else $error("pool order write did not start the clear pass");

   a_clr_only_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) && !csr_write_enable |-> (cmd.op == bal_pkg::OP_CLR))
      else $error("clear pass issued another operation");

endmodule
`default_nettype wire

// ----- hdl/buddy_allocator_core.sv -----
`default_nettype none
// Alloc: from accept, a scan up to the fitting order k, a scan for the first non-empty list at
//   or above k, the unlink, one split per order down to k; free: checks, one merge per order
//   grown; refusals end early. Requests: one at a time, next accept in the beat cycle; the
//   per-order scan and split/merge steps through the header and link memories set the spacing.
// Reset: synchronous; pool order MAX_POOL_ORDER (16 by default), then a clear pass of every
//   header with busy high; every pool order write repeats it. Receiver cannot stall.
module buddy_allocator_core #(
   parameter int MAX_POOL_ORDER  = bal_pkg::DEF_MAX_POOL_ORDER,
   parameter int MIN_BLOCK_ORDER = bal_pkg::DEF_MIN_BLOCK_ORDER,
   parameter int HEADER_BYTES    = bal_pkg::DEF_HEADER_BYTES
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request channel
   input  wire logic                      start,
   output logic                           busy,
   input  wire bal_pkg::req_type          req_payload,
   // result channel
   output logic                           rsp_strobe,
   output bal_pkg::rsp_type               rsp_payload,
   // pool order register
   input  wire logic                      csr_write_enable,
   input  wire logic [bal_pkg::CFG_W-1:0] csr_write_data
);

   bal_pkg::cmd_type  cmd;
   bal_pkg::stat_type stat;

   // sequencer: walks orders one step a cycle
   bal_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .csr_write_enable (csr_write_enable),
      .stat             (stat),
      .cmd              (cmd),
      .busy             (busy)
   );

   // memories, free list heads and the request registers
   bal_datapath #(
      .MAX_POOL_ORDER  (MAX_POOL_ORDER),
      .MIN_BLOCK_ORDER (MIN_BLOCK_ORDER),
      .HEADER_BYTES    (HEADER_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .stat             (stat),
      .rsp_strobe       (rsp_strobe),
      .rsp_payload      (rsp_payload)
   );

   // a result beat always lands as the sequencer goes back to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("rsp beat while busy");

endmodule
`default_nettype wire
